@@ design/dsh_pkg.sv @@
// Package for the diamond-square height map block: widths, constants, command
// and status structs shared by controller, datapath and top level.
// No dependencies.
`default_nettype none
package dsh_pkg;
    localparam int MaxOrder   = 8;
    localparam int SideMax    = (1 << MaxOrder) + 1;
    localparam int CoordW     = $clog2(SideMax);
    localparam int Depth      = SideMax * SideMax;
    localparam int AddrW      = $clog2(Depth);
    localparam int OrderW     = 4;
    localparam logic [47:0] LcgMul     = 48'h5DEECE66D;
    localparam logic [47:0] LcgAdd     = 48'hB;
    localparam logic [47:0] RandReset  = 48'h1234ABCD330E;
    localparam logic [15:0] SeedLow    = 16'h330E;
    localparam logic [23:0] ScaleStart = 24'd1677722;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StRange = 2'd1;
    localparam logic [1:0] StEmpty = 2'd2;

    localparam logic OpGen  = 1'b0;
    localparam logic OpRead = 1'b1;

    // datapath operations
    localparam logic [2:0] DpNop    = 3'd0;
    localparam logic [2:0] DpSeed   = 3'd1;
    localparam logic [2:0] DpLcgSum = 3'd2;
    localparam logic [2:0] DpAcc    = 3'd3;
    localparam logic [2:0] DpLcg    = 3'd4;
    localparam logic [2:0] DpRmul   = 3'd5;
    localparam logic [2:0] DpWrite  = 3'd6;
    localparam logic [2:0] DpScale  = 3'd7;

    typedef struct packed {
        logic [2:0]        op;
        logic [AddrW-1:0]  addr;
        logic              clr_acc;
        logic              corner;
        logic [31:0]       seed;
    } t_dp_cmd;

    typedef struct packed {
        logic [31:0] rd_data;
    } t_dp_stat;

    function automatic logic [AddrW-1:0] cell_addr(input logic [CoordW-1:0] r,
                                                  input logic [CoordW-1:0] c);
        logic [AddrW+CoordW-1:0] a;
        a = (AddrW+CoordW)'(r) * (AddrW+CoordW)'(SideMax) + (AddrW+CoordW)'(c);
        return a[AddrW-1:0];
    endfunction
endpackage
`default_nettype wire

@@ design/dsh_if.sv @@
// Valid/ready channel interfaces for input items and result items.
// Depends on dsh_pkg for coordinate width.
`default_nettype none
interface dsh_in_if;
    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [31:0]        seed;
    logic [dsh_pkg::CoordW-1:0] row;
    logic [dsh_pkg::CoordW-1:0] col;
    modport source (output valid, op, seed, row, col, input ready);
    modport sink   (input valid, op, seed, row, col, output ready);
endinterface

interface dsh_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] height;
    logic [1:0]         status;
    modport source (output valid, height, status, input ready);
    modport sink   (input valid, height, status, output ready);
endinterface
`default_nettype wire

@@ design/dsh_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module dsh_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_addr,
    input  wire logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]              o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ design/dsh_datapath.sv @@
// Datapath: generator state, scale, neighbor accumulator, random product and
// the grid memory. Depends on dsh_pkg and dsh_ram.
`default_nettype none
module dsh_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire dsh_pkg::t_dp_cmd i_cmd,
    output dsh_pkg::t_dp_stat     o_stat
);
    localparam logic [23:0] MulLo  = dsh_pkg::LcgMul[23:0];
    localparam logic [23:0] MulHi  = dsh_pkg::LcgMul[47:24];
    localparam logic [25:0] Recip5 = 26'd53687092;  // ceil(2^28 / 5)

    logic [47:0] r_rand, n_rand;
    logic [23:0] r_scale, n_scale;
    logic signed [33:0] r_acc, n_acc;
    logic [47:0] r_prod, n_prod;
    logic [23:0] r_mid, n_mid;
    logic [31:0] ram_rdata;
    logic        ram_we;
    logic signed [31:0] wdata;
    logic signed [34:0] v;
    logic [25:0] scale_num;
    logic [51:0] scale_q;
    logic [47:0] lcg_lo;
    logic [23:0] lcg_mid;

    // generator step: register the low partial product and the
    // cross terms that only reach the upper half, then sum them
    assign lcg_lo  = 48'(r_rand[23:0]) * 48'(MulLo);
    assign lcg_mid = r_rand[47:24] * MulLo + r_rand[23:0] * MulHi;

    assign scale_num = {1'b0, r_scale, 1'b0} + 26'd2;
    // divide by five by reciprocal multiplication, exact for this range
    assign scale_q   = 52'(scale_num) * 52'(Recip5);

    always_comb begin
        n_rand  = r_rand;
        n_scale = r_scale;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_mid   = r_mid;
        case (i_cmd.op)
            dsh_pkg::DpSeed: begin
                n_rand  = {i_cmd.seed, dsh_pkg::SeedLow};
                n_scale = dsh_pkg::ScaleStart;
            end
            dsh_pkg::DpAcc: begin
                n_acc = (i_cmd.clr_acc ? 34'sd0 : r_acc) + 34'(signed'(ram_rdata));
            end
            dsh_pkg::DpLcg: begin
                n_prod = lcg_lo;
                n_mid  = lcg_mid;
            end
            dsh_pkg::DpLcgSum: begin
                n_rand = r_prod + {r_mid, 24'd0} + dsh_pkg::LcgAdd;
            end
            dsh_pkg::DpRmul: begin
                n_prod = r_rand[47:24] * r_scale;
            end
            dsh_pkg::DpScale: begin
                n_scale = scale_q[51:28];
            end
            default: ;
        endcase
    end

    always_comb begin
        if (i_cmd.corner) begin
            v = 35'(signed'({1'b0, r_prod[47:24]}));
        end else begin
            v = 35'(r_acc >>> 2) + 35'(signed'({1'b0, r_prod[47:24]}))
                - 35'(signed'({1'b0, r_scale[23:1]}));
        end
        if (v > 35'sd2147483647) begin
            wdata = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            wdata = 32'sh80000000;
        end else begin
            wdata = v[31:0];
        end
    end

    assign ram_we = (i_cmd.op == dsh_pkg::DpWrite);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rand <= dsh_pkg::RandReset;
        end else begin
            r_rand <= n_rand;
        end
        r_scale <= n_scale;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_mid   <= n_mid;
    end

    dsh_ram #(.Width(32), .Depth(dsh_pkg::Depth)) u_grid (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (i_cmd.addr),
        .i_wdata(wdata),
        .o_rdata(ram_rdata)
    );

    assign o_stat.rd_data = ram_rdata;
endmodule
`default_nettype wire

@@ design/dsh_ctrl.sv @@
// Controller: walks corners, diamond and square passes, sequences reads,
// drives the datapath by command. Depends on dsh_pkg and dsh_if.
`default_nettype none
module dsh_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [dsh_pkg::OrderW-1:0]  i_order,
    dsh_in_if.sink                           in_ch,
    dsh_out_if.source                        out_ch,
    output dsh_pkg::t_dp_cmd                 o_cmd,
    input  wire dsh_pkg::t_dp_stat           i_stat
);
    localparam logic [3:0] SIdle  = 4'd0;
    localparam logic [3:0] SRd0   = 4'd1;
    localparam logic [3:0] SRd1   = 4'd2;
    localparam logic [3:0] SNbr   = 4'd3;  // issue neighbor reads
    localparam logic [3:0] SLcg   = 4'd4;
    localparam logic [3:0] SMul   = 4'd5;
    localparam logic [3:0] SWr    = 4'd6;
    localparam logic [3:0] SNext  = 4'd7;
    localparam logic [3:0] SOut   = 4'd8;
    localparam logic [3:0] SAccL  = 4'd9;  // last neighbor accumulate
    localparam logic [3:0] SLcg2  = 4'd10;

    localparam int CW = dsh_pkg::CoordW;
    localparam int OW = dsh_pkg::OrderW;

    logic [3:0]    r_state, n_state;
    logic          r_valid, n_valid;
    logic [CW:0]   r_side, n_side;     // side of map being built / stored
    logic [CW-1:0] r_step, n_step;
    logic [1:0]    r_phase, n_phase;   // 0 corners, 1 diamond, 2 square
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic          r_even, n_even;
    logic [2:0]    r_k, n_k;           // neighbor index / corner index
    logic [CW-1:0] r_rrow, n_rrow, r_rcol, n_rcol;
    logic          r_ov, n_ov;
    logic signed [31:0] r_h, n_h;
    logic [1:0]    r_st, n_st;
    logic [OW-1:0] kord;
    logic [CW:0]   nlast, h, tr, tc, ii, jj;
    logic [CW-1:0] nr, nc, wr, wc;

    always_comb begin
        kord = i_order;
        if (kord < OW'(1)) kord = OW'(1);
        if (kord > OW'(dsh_pkg::MaxOrder)) kord = OW'(dsh_pkg::MaxOrder);
    end

    assign nlast = r_side - (CW+1)'(1);
    assign h     = (CW+1)'(r_step >> 1);
    assign ii    = {1'b0, r_i};
    assign jj    = {1'b0, r_j};

    // neighbor coordinates for index r_k
    always_comb begin
        tr = ii; tc = jj;
        if (r_phase == 2'd1) begin
            tr = ii + ((r_k[0]) ? {1'b0, r_step} : '0);
            tc = jj + ((r_k[1]) ? {1'b0, r_step} : '0);
        end else begin
            case (r_k[1:0])
                2'd0: tc = (jj < h) ? nlast - h : jj - h;
                2'd1: tc = (jj + h >= r_side) ? h : jj + h;
                2'd2: tr = (ii + h >= r_side) ? h : ii + h;
                default: tr = (ii < h) ? nlast - h : ii - h;
            endcase
        end
        nr = tr[CW-1:0]; nc = tc[CW-1:0];
        // target cell
        if (r_phase == 2'd0) begin
            wr = r_k[1] ? nlast[CW-1:0] : '0;
            wc = r_k[0] ? nlast[CW-1:0] : '0;
        end else if (r_phase == 2'd1) begin
            wr = r_i + h[CW-1:0];
            wc = r_j + h[CW-1:0];
        end else begin
            wr = r_i; wc = r_j;
        end
    end

    always_comb begin
        n_state = r_state; n_valid = r_valid; n_side = r_side;
        n_step = r_step; n_phase = r_phase; n_i = r_i; n_j = r_j; n_even = r_even;
        n_k = r_k; n_rrow = r_rrow; n_rcol = r_rcol; n_ov = r_ov; n_h = r_h; n_st = r_st;
        o_cmd = '0;
        o_cmd.op = dsh_pkg::DpNop;
        o_cmd.seed = in_ch.seed;
        o_cmd.corner = (r_phase == 2'd0);
        o_cmd.addr = dsh_pkg::cell_addr(wr, wc);
        in_ch.ready = (r_state == SIdle);
        out_ch.valid = (r_state == SOut);
        case (r_state)
            SIdle: begin
                if (in_ch.valid) begin
                    if (in_ch.op == dsh_pkg::OpGen) begin
                        o_cmd.op = dsh_pkg::DpSeed;
                        n_side = (CW+1)'((1 << kord) + 1);
                        n_step = CW'(1 << kord);
                        n_phase = 2'd0; n_k = '0;
                        n_i = '0; n_j = '0; n_even = 1'b1;
                        n_state = SLcg;
                    end else begin
                        n_rrow = in_ch.row; n_rcol = in_ch.col;
                        n_ov = ({1'b0, in_ch.row} >= r_side) ||
                               ({1'b0, in_ch.col} >= r_side);
                        n_state = SRd0;
                    end
                end
            end
            SRd0: begin
                o_cmd.addr = dsh_pkg::cell_addr(r_rrow, r_rcol);
                n_state = SRd1;
            end
            SRd1: begin
                n_h = 32'sd0;
                if (!r_valid) begin
                    n_st = dsh_pkg::StEmpty;
                end else if (r_ov) begin
                    n_st = dsh_pkg::StRange;
                end else begin
                    n_st = dsh_pkg::StOk;
                    n_h = i_stat.rd_data;
                end
                n_state = SOut;
            end
            SNbr: begin
                // read neighbor k; accumulate neighbor k-1 arriving now
                o_cmd.addr = dsh_pkg::cell_addr(nr, nc);
                if (r_k != 3'd0) begin
                    o_cmd.op = dsh_pkg::DpAcc;
                    o_cmd.addr = dsh_pkg::cell_addr(nr, nc);
                    o_cmd.clr_acc = (r_k == 3'd1);
                end
                if (r_k == 3'd3) begin
                    n_state = SAccL;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            SAccL: begin
                o_cmd.op = dsh_pkg::DpAcc;
                n_state = SLcg;
            end
            SLcg: begin
                o_cmd.op = dsh_pkg::DpLcg;
                n_state = SLcg2;
            end
            SLcg2: begin
                o_cmd.op = dsh_pkg::DpLcgSum;
                n_state = SMul;
            end
            SMul: begin
                o_cmd.op = dsh_pkg::DpRmul;
                n_state = SWr;
            end
            SWr: begin
                o_cmd.op = dsh_pkg::DpWrite;
                n_state = SNext;
            end
            SNext: begin
                n_state = SNbr; n_k = '0;
                if (r_phase == 2'd0) begin
                    if (r_k == 3'd3) begin
                        n_phase = 2'd1; n_i = '0; n_j = '0;
                    end else begin
                        n_k = r_k + 3'd1; n_state = SLcg;
                    end
                end else if (r_phase == 2'd1) begin
                    if (jj + {1'b0, r_step} < nlast) begin
                        n_j = r_j + r_step;
                    end else if (ii + {1'b0, r_step} < nlast) begin
                        n_j = '0; n_i = r_i + r_step;
                    end else begin
                        n_phase = 2'd2; n_i = '0; n_even = 1'b1;
                        n_j = h[CW-1:0];
                    end
                end else begin
                    if (jj + {1'b0, r_step} < r_side) begin
                        n_j = r_j + r_step;
                    end else if (ii + h < r_side) begin
                        n_i = r_i + h[CW-1:0];
                        n_even = !r_even;
                        n_j = r_even ? '0 : h[CW-1:0];
                    end else begin
                        o_cmd.op = dsh_pkg::DpScale;
                        n_step = h[CW-1:0];
                        n_phase = 2'd1; n_i = '0; n_j = '0;
                        if (h == (CW+1)'(1)) begin
                            n_valid = 1'b1;
                            n_h = 32'sd0; n_st = dsh_pkg::StOk;
                            n_state = SOut;
                        end
                    end
                end
            end
            SOut: begin
                if (out_ch.ready) n_state = SIdle;
            end
            default: n_state = SIdle;
        endcase
    end

    assign out_ch.height = r_h;
    assign out_ch.status = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_valid <= 1'b0;
            r_side <= (CW+1)'(3);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_side <= n_side;
        end
        r_step <= n_step; r_phase <= n_phase; r_i <= n_i; r_j <= n_j;
        r_even <= n_even; r_k <= n_k; r_rrow <= n_rrow; r_rcol <= n_rcol;
        r_ov <= n_ov; r_h <= n_h; r_st <= n_st;
    end
endmodule
`default_nettype wire

@@ design/diamond_square_heightmap.sv @@
// Top level of the diamond-square height map block.
// Depends on dsh_pkg, dsh_if, dsh_ctrl, dsh_datapath, dsh_ram.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    op, seed, row, col
//   out_ch   out  valid/ready    height, status
//   cfg      in   i_cfg_we       i_cfg_data (grid_order)
//
// A read passes through four states: accept, address, memory data, result.
// A generate takes each corner through generator product, generator sum,
// random product, write and advance, and each other cell through four neighbor
// reads and a last accumulate before those steps, all on the single memory port.
// Reset is synchronous active low; the grid holds no reset value.
// The block holds one item at a time; a stalled result blocks intake.
`default_nettype none
module diamond_square_heightmap (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [dsh_pkg::OrderW-1:0]  i_cfg_data,
    dsh_in_if.sink                           in_ch,
    dsh_out_if.source                        out_ch
);
    logic [dsh_pkg::OrderW-1:0] r_order;
    dsh_pkg::t_dp_cmd  cmd;
    dsh_pkg::t_dp_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= dsh_pkg::OrderW'(8);
        end else if (i_cfg_we) begin
            r_order <= i_cfg_data;
        end
    end

    dsh_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_order(r_order),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .o_cmd  (cmd),
        .i_stat (stat)
    );

    dsh_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_stat (stat)
    );
endmodule
`default_nettype wire
